// ===== rtl/iscc_pkg.sv =====
// Shared constants, types and control structs for the insertion sorter.
`timescale 1ns / 1ps
`default_nettype none
package iscc_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int VAL_W     = 32;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int CMP_W     = 11;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [CNT_W-1:0]        count_t;
  typedef logic [CMP_W-1:0]        cmp_t;

  typedef enum logic [0:0] {
    ST_LOAD = 1'b0,
    ST_EMIT = 1'b1
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic insert;
    logic emit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic emit_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/iscc_ctrl.sv =====
// Controller: load / emit sequencing for the insertion sorter.
`timescale 1ns / 1ps
`default_nettype none
module iscc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          set_end,
  input  wire iscc_pkg::sts_t sts,
  output iscc_pkg::cmd_t     cmd,
  output logic               busy
);

  iscc_pkg::state_t state_r;
  iscc_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iscc_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      iscc_pkg::ST_LOAD: begin
        if (start && set_end) state_nxt = iscc_pkg::ST_EMIT;
      end
      iscc_pkg::ST_EMIT: begin
        if (sts.emit_last) state_nxt = iscc_pkg::ST_LOAD;
      end
      default: state_nxt = iscc_pkg::ST_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    cmd.insert = 1'b0;
    cmd.emit   = 1'b0;
    busy       = 1'b0;
    unique case (state_r)
      iscc_pkg::ST_LOAD: begin
        cmd.insert = start;
      end
      iscc_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        busy     = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/iscc_datapath.sv =====
// Datapath: chain of compare cells, item count, comparison count, overflow.
`timescale 1ns / 1ps
`default_nettype none
module iscc_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire iscc_pkg::cmd_t        cmd,
  input  wire iscc_pkg::value_t      item_value,
  output iscc_pkg::sts_t             sts,
  output iscc_pkg::value_t           sorted_value,
  output iscc_pkg::cmp_t             compare_total,
  output logic                       overflowed,
  output logic                       final_result
);

  localparam int N = iscc_pkg::MAX_ITEMS;

  iscc_pkg::value_t cell_r [N];
  iscc_pkg::count_t count_r;
  iscc_pkg::count_t count_nxt;
  iscc_pkg::cmp_t   cmp_r;
  iscc_pkg::cmp_t   cmp_nxt;
  logic             ovf_r;
  logic             ovf_nxt;

  logic [N-1:0]              gt;
  logic [N-1:0]              edge_hit;
  logic [iscc_pkg::IDX_W-1:0] edge_idx;
  iscc_pkg::count_t          pos;
  iscc_pkg::count_t          passed;
  logic                      full;
  logic                      last_out;

  // Per-cell compare: valid cells holding a value strictly above the new item
  always_comb begin
    for (int i = 0; i < N; i++) begin
      gt[i] = (iscc_pkg::count_t'(i) < count_r) && (cell_r[i] > item_value);
    end
  end

  // Boundary of the greater-than suffix, one-hot, then OR-encoded
  always_comb begin
    edge_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (i == 0) begin
        edge_hit[i] = gt[i];
      end else begin
        edge_hit[i] = gt[i] && !gt[i-1];
      end
      if (edge_hit[i]) edge_idx = edge_idx | iscc_pkg::IDX_W'(i);
    end
  end

  // Insert position and comparisons for this item
  always_comb begin
    pos    = (|gt) ? iscc_pkg::count_t'(edge_idx) : count_r;
    passed = (count_r - pos) + ((pos != '0) ? iscc_pkg::count_t'(1) : '0);
  end

  assign full     = (count_r == iscc_pkg::count_t'(N));
  assign last_out = (count_r == iscc_pkg::count_t'(1));

  // Counters and flags
  always_comb begin
    count_nxt = count_r;
    cmp_nxt   = cmp_r;
    ovf_nxt   = ovf_r;
    if (cmd.insert) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + iscc_pkg::count_t'(1);
        cmp_nxt   = cmp_r + iscc_pkg::cmp_t'(passed);
      end
    end else if (cmd.emit) begin
      count_nxt = count_r - iscc_pkg::count_t'(1);
      if (last_out) begin
        cmp_nxt = '0;
        ovf_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cmp_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      cmp_r   <= cmp_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Cell chain: shift up past the insert point on load, shift down on emit
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (cmd.insert && !full) begin
        if (i > 0 && gt[(i > 0) ? i-1 : 0]) begin
          cell_r[i] <= cell_r[(i > 0) ? i-1 : 0];
        end else if (gt[i] || (iscc_pkg::count_t'(i) == count_r)) begin
          cell_r[i] <= item_value;
        end
      end else if (cmd.emit) begin
        if (i < N-1) begin
          cell_r[i] <= cell_r[(i < N-1) ? i+1 : i];
        end
      end
    end
  end

  // The sorted value comes straight from the head of the chain; the other fields come from the counters
  assign sorted_value  = cell_r[0];
  assign compare_total = cmp_r;
  assign overflowed    = ovf_r;
  assign final_result  = last_out;
  assign sts.emit_last = last_out;

endmodule
`default_nettype wire

// ===== rtl/insertion_sort_with_compare_count.sv =====
// Insertion sorter with comparison count: top level.
// Loading takes one item per cycle while busy is low; each accepted item is inserted into the
// cell chain at the edge that accepts it. The item with set_end closes the set:
// busy then rises and one result per stored value follows on consecutive cycles,
// the first in the cycle right after that edge; busy drops after the final one.
// Synchronous active-low reset empties the set and clears the counts and flag.
`timescale 1ns / 1ps
`default_nettype none
module insertion_sort_with_compare_count (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic signed [31:0]       in_item_value,
  input  wire logic                     in_set_end,
  output logic                          out_valid,
  output logic signed [31:0]            out_sorted_value,
  output logic [10:0]                   out_compare_total,
  output logic                          out_overflowed,
  output logic                          out_final_result
);

  iscc_pkg::cmd_t cmd;
  iscc_pkg::sts_t sts;

  // Sequencing
  iscc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .set_end (in_set_end),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  // Storage and arithmetic
  iscc_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .item_value    (in_item_value),
    .sts           (sts),
    .sorted_value  (out_sorted_value),
    .compare_total (out_compare_total),
    .overflowed    (out_overflowed),
    .final_result  (out_final_result)
  );

  assign out_valid = cmd.emit;

endmodule
`default_nettype wire
